[src/date_day_number_difference_top_defines.svh]
// Assertion macros for the date day number block.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef DATE_DAY_NUMBER_DIFFERENCE_TOP_DEFINES_SVH
`define DATE_DAY_NUMBER_DIFFERENCE_TOP_DEFINES_SVH

// same-cycle implication
`define DD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/dd_pkg.sv]
// Package for the date day number block: field widths, lane types,
// month table and mod-7 helper. No dependencies.
`timescale 1ns / 1ps

package dd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int NUM_W   = 23;   // exact day number of any 14-bit year
    localparam int OUTN_W  = 22;
    localparam int DIFF_W  = 23;
    localparam int WD_W    = 3;
    localparam int CUM_W   = 9;

    localparam int unsigned DAYS_PER_YEAR = 365;
    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x < 43690
    localparam int unsigned RECIP_100   = 5243;
    localparam int          RECIP_SHIFT = 19;
    localparam int          PROD_W      = 27;
    localparam int          Q100_W      = PROD_W - RECIP_SHIFT;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    typedef struct packed {
        logic [NUM_W-1:0] num;
    } t_lane_res;

    // days before the first of the month, common year; 13..15 see the full year
    function automatic logic [CUM_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
        logic [CUM_W-1:0] v;
        case (m)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd365;
        endcase
        return v;
    endfunction

    // 8 == 1 mod 7, so fold 3-bit digits
    function automatic logic [WD_W-1:0] mod7(input logic [NUM_W-1:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [WD_W-1:0] r;
        s1 = 6'({3'b0, x[2:0]}) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9])
           + 6'(x[14:12]) + 6'(x[17:15]) + 6'(x[20:18]) + 6'(x[22:21]);
        s2 = 4'({1'b0, s1[2:0]}) + 4'(s1[5:3]);
        if (s2 >= 4'd14) begin
            r = 3'd0;
        end else if (s2 >= 4'd7) begin
            r = 3'(s2 - 4'd7);
        end else begin
            r = s2[2:0];
        end
        return r;
    endfunction

endpackage

[src/dd_if.sv]
// Valid/ready channel interfaces for the date pair input and the result.
// Depends on dd_pkg for field widths.
`timescale 1ns / 1ps

interface dd_in_if import dd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  year_a;
    logic [MONTH_W-1:0] month_a;
    logic [DAY_W-1:0]   day_a;
    logic [YEAR_W-1:0]  year_b;
    logic [MONTH_W-1:0] month_b;
    logic [DAY_W-1:0]   day_b;

    modport source (output valid, year_a, month_a, day_a, year_b, month_b, day_b,
                    input ready);
    modport sink   (input valid, year_a, month_a, day_a, year_b, month_b, day_b,
                    output ready);
endinterface

interface dd_out_if import dd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OUTN_W-1:0]        day_number_a;
    logic signed [DIFF_W-1:0] day_difference;
    logic [WD_W-1:0]          weekday_a;
    logic [WD_W-1:0]          weekday_b;

    modport source (output valid, day_number_a, day_difference, weekday_a, weekday_b,
                    input ready);
    modport sink   (input valid, day_number_a, day_difference, weekday_a, weekday_b,
                    output ready);
endinterface

[src/date_day_number_difference_top.sv]
// Top level of the date day number block: two lanes and a merge stage.
// Depends on dd_pkg, dd_if, dd_lane, dd_merge and the defines header.
//
//   channel  dir  beat contents
//   i_in     in   year/month/day of dates A and B
//   o_out    out  day_number_a, day_difference, weekday_a, weekday_b
//
// One beat accepted per cycle while the output is not stalled; an accepted
// beat passes three lane stages and the merge output register to o_out.
// Reset clears the stage valid bits only.
// A stalled output freezes the whole pipeline; i_in.ready follows it.
`timescale 1ns / 1ps
`include "date_day_number_difference_top_defines.svh"

module date_day_number_difference_top import dd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dd_in_if.sink    i_in,
    dd_out_if.source o_out
);

    logic      w_adv;
    logic [2:0] r_vld;
    t_date     w_date_a, w_date_b;
    t_lane_res w_res_a, w_res_b;

    assign i_in.ready = w_adv;

    assign w_date_a = '{year: i_in.year_a, month: i_in.month_a, day: i_in.day_a};
    assign w_date_b = '{year: i_in.year_b, month: i_in.month_b, day: i_in.day_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[1:0], i_in.valid};
        end
    end

    dd_lane u_lane_a (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_date (w_date_a),
        .o_res  (w_res_a)
    );

    dd_lane u_lane_b (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_date (w_date_b),
        .o_res  (w_res_b)
    );

    dd_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld[2]),
        .i_res_a (w_res_a),
        .i_res_b (w_res_b),
        .o_adv   (w_adv),
        .o_out   (o_out)
    );

    `DD_ASSERT_NXT(a_accept_enters, i_in.valid && i_in.ready, r_vld[0], "accepted beat lost")
    `DD_ASSERT_NXT(a_last_to_out, r_vld[2] && w_adv, o_out.valid, "beat lost at merge")
    `DD_ASSERT_NXT(a_stall_freeze, !w_adv, $stable(r_vld), "pipeline moved during stall")
    `DD_ASSERT_IMP(a_weekday_range, o_out.valid,
                   (o_out.weekday_a <= 3'd6) && (o_out.weekday_b <= 3'd6), "weekday out of range")

endmodule

[src/dd_lane.sv]
// One date-to-day-number lane, three register stages.
// Depends on dd_pkg.
`timescale 1ns / 1ps

module dd_lane import dd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_en,
    input  t_date     i_date,
    output t_lane_res o_res
);

    // stage 1: products
    logic [NUM_W-1:0]   r_p365, n_p365;
    logic [YEAR_W-3:0]  r_p4, n_p4;
    logic [PROD_W-1:0]  r_pprod, n_pprod;
    logic [PROD_W-1:0]  r_yprod, n_yprod;
    logic [YEAR_W-1:0]  r_y1;
    logic [CUM_W-1:0]   r_cum1;
    logic               r_late1;
    logic [DAY_W-1:0]   r_d1;
    logic [YEAR_W-1:0]  w_p;

    // stage 2: year base and in-year offset
    logic [NUM_W-1:0]   r_base, n_base;
    logic [CUM_W:0]     r_rest, n_rest;
    logic [Q100_W-1:0]  w_qp, w_qy;
    logic               w_div100, w_leap;

    // stage 3
    logic [NUM_W-1:0]   r_num, n_num;

    always_comb begin
        w_p     = (i_date.year != '0) ? i_date.year - 1'b1 : '0;
        n_p365  = NUM_W'(w_p) * NUM_W'(DAYS_PER_YEAR);
        n_p4    = w_p[YEAR_W-1:2];
        n_pprod = PROD_W'(w_p) * PROD_W'(RECIP_100);
        n_yprod = PROD_W'(i_date.year) * PROD_W'(RECIP_100);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p365  <= n_p365;
            r_p4    <= n_p4;
            r_pprod <= n_pprod;
            r_yprod <= n_yprod;
            r_y1    <= i_date.year;
            r_cum1  <= cum_days(i_date.month);
            r_late1 <= (i_date.month > 4'd2);
            r_d1    <= i_date.day;
        end
    end

    always_comb begin
        w_qp     = r_pprod[PROD_W-1:RECIP_SHIFT];
        w_qy     = r_yprod[PROD_W-1:RECIP_SHIFT];
        w_div100 = (r_y1 == YEAR_W'(YEAR_W'(w_qy) * YEAR_W'(100)));
        w_leap   = ((r_y1[1:0] == 2'b00) && !w_div100) || (w_div100 && (w_qy[1:0] == 2'b00));
        n_base   = r_p365 + NUM_W'(r_p4) + NUM_W'(w_qp[Q100_W-1:2]) - NUM_W'(w_qp);
        n_rest   = (CUM_W+1)'(r_cum1) + (CUM_W+1)'(r_late1 & w_leap) + (CUM_W+1)'(r_d1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_base <= n_base;
            r_rest <= n_rest;
        end
    end

    assign n_num = r_base + NUM_W'(r_rest);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= n_num;
        end
    end

    assign o_res.num = r_num;

endmodule

[src/dd_merge.sv]
// Merge stage: difference and weekdays from both lanes, output register.
// Depends on dd_pkg and dd_out_if.
`timescale 1ns / 1ps

module dd_merge import dd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_vld,
    input  t_lane_res i_res_a,
    input  t_lane_res i_res_b,
    output logic      o_adv,
    dd_out_if.source  o_out
);

    logic                     r_valid;
    logic [OUTN_W-1:0]        r_num_a;
    logic signed [DIFF_W-1:0] r_diff, n_diff;
    logic [WD_W-1:0]          r_wd_a, r_wd_b;

    assign o_adv  = !r_valid || o_out.ready;
    assign n_diff = DIFF_W'(i_res_a.num - i_res_b.num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_num_a <= i_res_a.num[OUTN_W-1:0];
            r_diff  <= n_diff;
            r_wd_a  <= mod7(i_res_a.num);
            r_wd_b  <= mod7(i_res_b.num);
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.day_number_a   = r_num_a;
    assign o_out.day_difference = r_diff;
    assign o_out.weekday_a      = r_wd_a;
    assign o_out.weekday_b      = r_wd_b;

endmodule
